@@ src/dlps_pkg.sv @@
`default_nettype none
package dlps_pkg;

   localparam int unsigned NUM_BUTTONS = 3;
   localparam int unsigned BTN_START   = 0;
   localparam int unsigned BTN_SPEED   = 1;
   localparam int unsigned BTN_PATTERN = 2;

   localparam int unsigned CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_SLOW_PERIOD     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAST_PERIOD     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_LENGTH = 2'd2;

   localparam logic [7:0] SLOW_PERIOD_RST     = 8'hC8;
   localparam logic [7:0] FAST_PERIOD_RST     = 8'h64;
   localparam logic [7:0] DEBOUNCE_LENGTH_RST = 8'h05;

   localparam logic [7:0] LED_ALL_ON = 8'hFF;
   localparam logic [7:0] LED_TOP    = 8'h80;

   localparam logic [2:0] PAT_INVERT  = 3'd0;
   localparam logic [2:0] PAT_WALK    = 3'd1;
   localparam logic [2:0] PAT_TABLE_A = 3'd2;
   localparam logic [2:0] PAT_TABLE_B = 3'd3;
   localparam logic [2:0] PAT_SHIFT   = 3'd4;
   localparam logic [2:0] PAT_COUNT   = 3'd5;

   localparam logic [3:0] TABLE_A_LEN = 4'd6;
   localparam logic [3:0] TABLE_B_LEN = 4'd12;

   localparam logic [7:0] TABLE_A [16] = '{
      8'h81, 8'h42, 8'h24, 8'h18, 8'h24, 8'h42, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   localparam logic [7:0] TABLE_B [16] = '{
      8'h01, 8'h02, 8'h03, 8'h05, 8'h08, 8'h0D, 8'h15, 8'h22,
      8'h37, 8'h59, 8'h90, 8'hE9, 8'h00, 8'h00, 8'h00, 8'h00
   };

   localparam logic [8:0] SHIFT_FIRST_RST  = 9'd1;
   localparam logic [8:0] SHIFT_SECOND_RST = 9'd2;
   localparam logic [8:0] SHIFT_LIMIT      = 9'h080;

   typedef struct packed {
      logic frame;
      logic edge_start;
      logic edge_speed;
      logic edge_pattern;
   } seq_ctrl_type;

   typedef struct packed {
      logic [7:0] led;
      logic [3:0] step;
      logic [8:0] shift_first;
      logic [8:0] shift_second;
   } pat_state_type;

   function automatic pat_state_type run_pattern(input logic [2:0] code,
                                                 input pat_state_type cur);
      pat_state_type nxt;
      logic [8:0]    sf;
      logic [8:0]    ss;
      logic [8:0]    sum;
      nxt = cur;
      sf  = cur.shift_first;
      ss  = cur.shift_second;
      sum = '0;
      unique case (code)
         PAT_INVERT: begin
            nxt.led = ~cur.led;
         end
         PAT_WALK: begin
            if (cur.led == 8'h00 || cur.led == LED_TOP) begin
               nxt.led = 8'h01;
            end else begin
               nxt.led = {cur.led[6:0], 1'b0};
            end
         end
         PAT_TABLE_A: begin
            nxt.step = (cur.step >= TABLE_A_LEN) ? 4'd0 : cur.step;
            nxt.led  = TABLE_A[nxt.step];
            nxt.step = nxt.step + 4'd1;
         end
         PAT_TABLE_B: begin
            nxt.step = (cur.step >= TABLE_B_LEN) ? 4'd0 : cur.step;
            nxt.led  = TABLE_B[nxt.step];
            nxt.step = nxt.step + 4'd1;
         end
         PAT_SHIFT: begin
            if (sf > SHIFT_LIMIT) begin
               sf = 9'd1;
            end
            if (ss > SHIFT_LIMIT) begin
               ss = 9'd1;
            end
            sum              = sf + ss;
            nxt.led          = sum[7:0];
            nxt.shift_first  = {sf[7:0], 1'b0};
            nxt.shift_second = {ss[7:0], 1'b0};
         end
         default: begin
            nxt.led = 8'h00;
         end
      endcase
      return nxt;
   endfunction

endpackage
`default_nettype wire

@@ src/dlps_lane.sv @@
`default_nettype none
module dlps_lane (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       tick,
   input  wire logic       frame,
   input  wire logic       raw,
   input  wire logic [7:0] debounce_length,
   output logic            rise
);
   import dlps_pkg::*;

   logic       raw_prev_ff;
   logic       stable_ff;
   logic       stable_prev_ff;
   logic [7:0] count_ff;
   logic [7:0] count_in;
   logic [7:0] count_inc;
   logic       stable_in;

   always_comb begin
      count_inc = count_ff + 8'd1;
      count_in  = count_ff;
      stable_in = stable_ff;
      if (raw == raw_prev_ff) begin
         count_in = count_inc;
         if (count_inc == debounce_length) begin
            count_in  = 8'd0;
            stable_in = raw;
         end
      end else begin
         count_in = 8'd0;
      end
   end

   assign rise = stable_in & ~stable_prev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_prev_ff    <= 1'b1;
         stable_ff      <= 1'b1;
         stable_prev_ff <= 1'b1;
         count_ff       <= 8'd0;
      end else if (tick) begin
         raw_prev_ff <= raw;
         stable_ff   <= stable_in;
         count_ff    <= count_in;
         if (frame) begin
            stable_prev_ff <= stable_in;
         end
      end
   end

endmodule
`default_nettype wire

@@ src/dlps_sequencer.sv @@
`default_nettype none
module dlps_sequencer (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire dlps_pkg::seq_ctrl_type ctrl,
   input  wire logic [7:0]           slow_period,
   input  wire logic [7:0]           fast_period,
   output logic [7:0]                period_now,
   output logic [7:0]                led_value
);
   import dlps_pkg::*;

   logic          running_ff, running_in;
   logic          fast_ff, fast_in;
   logic          chosen_ff, chosen_in;
   logic [2:0]    select_ff, select_in;
   logic [7:0]    period_ff, period_in;
   pat_state_type pat_ff, pat_in;

   always_comb begin
      running_in = running_ff;
      fast_in    = fast_ff;
      chosen_in  = chosen_ff;
      select_in  = select_ff;
      period_in  = period_ff;
      pat_in     = pat_ff;
      if (ctrl.edge_start) begin
         if (!running_ff) begin
            running_in = 1'b1;
            pat_in.led = LED_ALL_ON;
         end else begin
            running_in  = 1'b0;
            fast_in     = 1'b0;
            select_in   = 3'd0;
            chosen_in   = 1'b0;
            period_in   = slow_period;
            pat_in.step = 4'd0;
         end
      end
      if (running_in) begin
         if (ctrl.edge_speed) begin
            fast_in   = ~fast_in;
            period_in = fast_in ? fast_period : slow_period;
         end
         if (ctrl.edge_pattern) begin
            chosen_in   = 1'b1;
            pat_in.led  = 8'h00;
            pat_in.step = 4'd0;
            if (select_in == PAT_COUNT) begin
               select_in = 3'd0;
            end
            pat_in    = run_pattern(select_in, pat_in);
            select_in = select_in + 3'd1;
         end else if (chosen_in) begin
            pat_in = run_pattern(select_in - 3'd1, pat_in);
         end
      end else begin
         pat_in.led = 8'h00;
      end
   end

   assign period_now = period_ff;
   assign led_value  = pat_in.led;

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff          <= 1'b0;
         fast_ff             <= 1'b0;
         chosen_ff           <= 1'b0;
         select_ff           <= 3'd0;
         period_ff           <= SLOW_PERIOD_RST;
         pat_ff.led          <= 8'h00;
         pat_ff.step         <= 4'd0;
         pat_ff.shift_first  <= SHIFT_FIRST_RST;
         pat_ff.shift_second <= SHIFT_SECOND_RST;
      end else if (ctrl.frame) begin
         running_ff <= running_in;
         fast_ff    <= fast_in;
         chosen_ff  <= chosen_in;
         select_ff  <= select_in;
         period_ff  <= period_in;
         pat_ff     <= pat_in;
      end
   end

endmodule
`default_nettype wire

@@ src/debounced_led_pattern_sequencer.sv @@
`default_nettype none
// The LED beat of a frame tick is registered in the result queue and offered on rsp_ from there.
// One tick is taken per clock while req_stall is low; the three button lanes and the frame logic are combinational.
// A two-entry result queue absorbs rsp_stall; req_stall rises only when both entries are full.
// Reset (synchronous, active high): registers return to 200/100/5, buttons read released,
// the block is stopped in slow mode and the result queue is emptied.
module debounced_led_pattern_sequencer (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_raw_start,
   input  wire logic                            req_raw_speed,
   input  wire logic                            req_raw_pattern,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [7:0]                           rsp_led_value,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [dlps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]                      csr_data
);
   import dlps_pkg::*;

   logic [7:0] slow_period_ff;
   logic [7:0] fast_period_ff;
   logic [7:0] debounce_length_ff;
   logic [7:0] tick_count_ff, tick_count_in;
   logic [7:0] tick_inc;
   logic [7:0] period_now;
   logic [7:0] led_value;
   logic       tick;
   logic       frame;
   logic [NUM_BUTTONS-1:0] raw;
   logic [NUM_BUTTONS-1:0] rise;
   seq_ctrl_type ctrl;

   logic [7:0] q0_ff, q1_ff;
   logic [1:0] q_count_ff;
   logic       push;
   logic       pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         slow_period_ff     <= SLOW_PERIOD_RST;
         fast_period_ff     <= FAST_PERIOD_RST;
         debounce_length_ff <= DEBOUNCE_LENGTH_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SLOW_PERIOD:     slow_period_ff     <= csr_data;
            CSR_FAST_PERIOD:     fast_period_ff     <= csr_data;
            CSR_DEBOUNCE_LENGTH: debounce_length_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_stall = (q_count_ff == 2'd2);
   assign tick      = req_valid & ~req_stall;
   assign tick_inc  = tick_count_ff + 8'd1;
   assign frame     = tick & (tick_inc == period_now);
   assign tick_count_in = frame ? 8'd0 : tick_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= 8'd0;
      end else if (tick) begin
         tick_count_ff <= tick_count_in;
      end
   end

   assign raw[BTN_START]   = req_raw_start;
   assign raw[BTN_SPEED]   = req_raw_speed;
   assign raw[BTN_PATTERN] = req_raw_pattern;

   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
      dlps_lane u_lane (
         .clock           (clock),
         .reset           (reset),
         .tick            (tick),
         .frame           (frame),
         .raw             (raw[i]),
         .debounce_length (debounce_length_ff),
         .rise            (rise[i])
      );
   end

   assign ctrl.frame        = frame;
   assign ctrl.edge_start   = frame & rise[BTN_START];
   assign ctrl.edge_speed   = frame & rise[BTN_SPEED];
   assign ctrl.edge_pattern = frame & rise[BTN_PATTERN];

   dlps_sequencer u_seq (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .slow_period (slow_period_ff),
      .fast_period (fast_period_ff),
      .period_now  (period_now),
      .led_value   (led_value)
   );

   assign rsp_valid     = (q_count_ff != 2'd0);
   assign rsp_led_value = q0_ff;
   assign pop           = rsp_valid & ~rsp_stall;
   assign push          = frame;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_count_ff <= 2'd0;
      end else begin
         if (push && !pop) begin
            q_count_ff <= q_count_ff + 2'd1;
         end else if (pop && !push) begin
            q_count_ff <= q_count_ff - 2'd1;
         end
      end
      if (pop) begin
         if (push && q_count_ff == 2'd1) begin
            q0_ff <= led_value;
         end else begin
            q0_ff <= q1_ff;
            if (push) begin
               q1_ff <= led_value;
            end
         end
      end else if (push) begin
         if (q_count_ff == 2'd0) begin
            q0_ff <= led_value;
         end else begin
            q1_ff <= led_value;
         end
      end
   end

endmodule
`default_nettype wire

@@ tb/sv/debounced_led_pattern_sequencer_tb.sv @@
`default_nettype none
module debounced_led_pattern_sequencer_tb;
   import dlps_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   localparam logic [2:0] RELEASED    = 3'b111;
   localparam logic [2:0] START_KEY   = 3'b001 << BTN_START;
   localparam logic [2:0] SPEED_KEY   = 3'b001 << BTN_SPEED;
   localparam logic [2:0] PATTERN_KEY = 3'b001 << BTN_PATTERN;

   // entry 0 sits in the low byte
   localparam logic [47:0] RING_LEDS = {8'h42, 8'h24, 8'h18, 8'h24, 8'h42, 8'h81};
   localparam logic [95:0] FIB_LEDS  = {8'hE9, 8'h90, 8'h59, 8'h37, 8'h22, 8'h15,
                                        8'h0D, 8'h08, 8'h05, 8'h03, 8'h02, 8'h01};

   logic                   clock           = 1'b0;
   logic                   reset           = 1'b1;
   logic                   req_valid       = 1'b0;
   logic                   req_stall;
   logic                   req_raw_start   = 1'b1;
   logic                   req_raw_speed   = 1'b1;
   logic                   req_raw_pattern = 1'b1;
   logic                   rsp_valid;
   logic                   rsp_stall       = 1'b0;
   logic [7:0]             rsp_led_value;
   logic                   csr_valid       = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index       = CSR_SLOW_PERIOD;
   logic [7:0]             csr_data        = 8'h00;

   // sequencer state as predicted
   logic [7:0] slow_reg, fast_reg, debounce_reg;
   logic [7:0] frame_timer, frame_period;
   logic [2:0] last_raw, settled, settled_at_frame;
   logic [7:0] settle_count [3];
   logic       is_running, is_fast, has_pattern;
   logic [2:0] next_pattern;
   logic [3:0] table_pos;
   logic [8:0] bit_a, bit_b;
   logic [7:0] led_now;
   logic [7:0] led_expected [$];

   int req_idle_pct   = 0;
   int rsp_stall_pct  = 0;
   int ticks_sent     = 0;
   int mismatch_count = 0;
   int beat_count     = 0;
   int cycle_count    = 0;

   debounced_led_pattern_sequencer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_raw_start   (req_raw_start),
      .req_raw_speed   (req_raw_speed),
      .req_raw_pattern (req_raw_pattern),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_led_value   (rsp_led_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task clear_sequencer_model();
      slow_reg         = SLOW_PERIOD_RST;
      fast_reg         = FAST_PERIOD_RST;
      debounce_reg     = DEBOUNCE_LENGTH_RST;
      frame_timer      = 8'd0;
      frame_period     = SLOW_PERIOD_RST;
      last_raw         = RELEASED;
      settled          = RELEASED;
      settled_at_frame = RELEASED;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         settle_count[b] = 8'd0;
      end
      is_running   = 1'b0;
      is_fast      = 1'b0;
      has_pattern  = 1'b0;
      next_pattern = PAT_INVERT;
      table_pos    = 4'd0;
      bit_a        = SHIFT_FIRST_RST;
      bit_b        = SHIFT_SECOND_RST;
      led_now      = 8'h00;
      led_expected.delete();
   endtask

   task automatic step_pattern(input logic [2:0] code);
      case (code)
         PAT_INVERT: begin
            led_now = ~led_now;
         end
         PAT_WALK: begin
            led_now = (led_now == 8'h00 || led_now == LED_TOP) ? 8'h01 : {led_now[6:0], 1'b0};
         end
         PAT_TABLE_A: begin
            if (table_pos >= TABLE_A_LEN) table_pos = 4'd0;
            led_now   = RING_LEDS[table_pos*8 +: 8];
            table_pos = table_pos + 4'd1;
         end
         PAT_TABLE_B: begin
            if (table_pos >= TABLE_B_LEN) table_pos = 4'd0;
            led_now   = FIB_LEDS[table_pos*8 +: 8];
            table_pos = table_pos + 4'd1;
         end
         PAT_SHIFT: begin
            if (bit_a > SHIFT_LIMIT) bit_a = 9'd1;
            if (bit_b > SHIFT_LIMIT) bit_b = 9'd1;
            led_now = 8'(bit_a + bit_b);
            bit_a   = {bit_a[7:0], 1'b0};
            bit_b   = {bit_b[7:0], 1'b0};
         end
         default: begin
            led_now = 8'h00;
         end
      endcase
   endtask

   task automatic predict_led_frame(input logic [2:0] raw);
      logic       frame;
      logic [2:0] rise;
      frame_timer = frame_timer + 8'd1;
      frame       = (frame_timer == frame_period);
      if (frame) frame_timer = 8'd0;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         if (raw[b] == last_raw[b]) begin
            settle_count[b] = settle_count[b] + 8'd1;
            if (settle_count[b] == debounce_reg) begin
               settle_count[b] = 8'd0;
               settled[b]      = raw[b];
            end
         end else begin
            settle_count[b] = 8'd0;
         end
      end
      last_raw = raw;
      if (frame) begin
         rise = settled & ~settled_at_frame;
         if (rise[BTN_START]) begin
            if (!is_running) begin
               is_running = 1'b1;
               led_now    = LED_ALL_ON;
            end else begin
               is_running   = 1'b0;
               is_fast      = 1'b0;
               next_pattern = PAT_INVERT;
               has_pattern  = 1'b0;
               frame_period = slow_reg;
               table_pos    = 4'd0;
            end
         end
         if (is_running) begin
            if (rise[BTN_SPEED]) begin
               is_fast      = !is_fast;
               frame_period = is_fast ? fast_reg : slow_reg;
            end
            if (rise[BTN_PATTERN]) begin
               has_pattern = 1'b1;
               led_now     = 8'h00;
               table_pos   = 4'd0;
               if (next_pattern == PAT_COUNT) next_pattern = PAT_INVERT;
               step_pattern(next_pattern);
               next_pattern = next_pattern + 3'd1;
            end else if (has_pattern) begin
               step_pattern(next_pattern - 3'd1);
            end
         end else begin
            led_now = 8'h00;
         end
         settled_at_frame = settled;
         led_expected.push_back(led_now);
      end
   endtask

   task report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
      mismatch_count++;
      if (mismatch_count <= 50) begin
         $display("LED mismatch at beat %0d (%s): got %02h, expected %02h",
                  beat_count, what, got, want);
      end
   endtask

   always @(posedge clock) begin : sequencer_monitor
      logic [2:0] raw;
      logic [7:0] want;
      if (reset) begin
         clear_sequencer_model();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SLOW_PERIOD:     slow_reg     = csr_data;
               CSR_FAST_PERIOD:     fast_reg     = csr_data;
               CSR_DEBOUNCE_LENGTH: debounce_reg = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            raw[BTN_START]   = req_raw_start;
            raw[BTN_SPEED]   = req_raw_speed;
            raw[BTN_PATTERN] = req_raw_pattern;
            predict_led_frame(raw);
         end
         if (rsp_valid && !rsp_stall) begin
            beat_count++;
            if (led_expected.size() == 0) begin
               report_mismatch("beat with no frame pending", rsp_led_value, 8'h00);
            end else begin
               want = led_expected.pop_front();
               if (rsp_led_value !== want) report_mismatch("led_value", rsp_led_value, want);
            end
         end
      end
   end

   task send_tick(input logic [2:0] levels);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_raw_start   <= levels[BTN_START];
      req_raw_speed   <= levels[BTN_SPEED];
      req_raw_pattern <= levels[BTN_PATTERN];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ticks_sent++;
   endtask

   task drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (led_expected.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task put_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task set_regs(input logic [7:0] slow, input logic [7:0] fast, input logic [7:0] debounce);
      drain_results();
      put_reg(CSR_SLOW_PERIOD, slow);
      put_reg(CSR_FAST_PERIOD, fast);
      put_reg(CSR_DEBOUNCE_LENGTH, debounce);
      csr_valid <= 1'b0;
   endtask

   // hold keys low, then released, each long enough to be seen settled at a frame
   task press(input logic [2:0] keys, input int extra);
      int hold;
      hold = debounce_reg + frame_period + 1 + extra;
      repeat (hold) send_tick(~keys);
      repeat (hold) send_tick(RELEASED);
   endtask

   task random_episode();
      int         kind;
      int         len;
      logic [2:0] keys;
      kind              = $urandom_range(9);
      keys[BTN_START]   = ($urandom_range(3) == 0);
      keys[BTN_SPEED]   = 1'($urandom_range(1));
      keys[BTN_PATTERN] = 1'($urandom_range(1));
      if (keys == 3'b000) keys = PATTERN_KEY;
      if (kind < 7) begin
         press(keys, $urandom_range(0, frame_period));
      end else if (kind == 7) begin
         // bounce no longer than the debounce length
         len = $urandom_range(1, debounce_reg);
         repeat (len) send_tick(~keys);
         send_tick(RELEASED);
      end else begin
         len = $urandom_range(1, 20);
         repeat (len) send_tick(3'($urandom));
      end
   endtask

   task test_reset_values_all_keys();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      // start, speed toggle and first pattern land on one frame
      press(START_KEY | SPEED_KEY | PATTERN_KEY, 0);
   endtask

   task test_pattern_cycle();
      set_regs(8'd3, 8'd1, 8'd1);
      req_idle_pct  = 55;
      rsp_stall_pct = 0;
      press(SPEED_KEY, 0);
      repeat (6) begin
         press(PATTERN_KEY, 0);
         repeat (40) send_tick(RELEASED);
      end
   endtask

   task test_stop_restart_fast();
      req_idle_pct  = 0;
      rsp_stall_pct = 55;
      press(START_KEY, 0);
      repeat (5) send_tick(RELEASED);
      press(START_KEY | SPEED_KEY, 0);
      press(PATTERN_KEY, 2);
      repeat (12) send_tick(RELEASED);
      press(SPEED_KEY, 0);
      press(START_KEY, 0);
      press(SPEED_KEY | PATTERN_KEY, 0);
   endtask

   task test_long_periods();
      set_regs(8'd1, 8'd255, 8'd255);
      req_idle_pct  = 37;
      rsp_stall_pct = 37;
      press(START_KEY | SPEED_KEY, 0);
      set_regs(8'd1, 8'd255, 8'd1);
      press(SPEED_KEY | PATTERN_KEY, 0);
      repeat (20) send_tick(RELEASED);
   endtask

   task run_random_phase(input logic [7:0] slow, input logic [7:0] fast,
                         input logic [7:0] debounce, input int idle_pct,
                         input int stall_pct, input int budget);
      int first;
      set_regs(slow, fast, debounce);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      first         = ticks_sent;
      while (ticks_sent - first < budget) random_episode();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_values_all_keys();
      test_pattern_cycle();
      test_stop_restart_fast();
      test_long_periods();
      run_random_phase(8'd5, 8'd2, 8'd3, 0, 0, 100);
      run_random_phase(8'd60, 8'd1, 8'd2, 55, 0, 100);
      run_random_phase(8'd1, 8'd7, 8'd1, 0, 55, 100);
      run_random_phase(8'd2, 8'd4, 8'd6, 37, 37, 100);
      drain_results();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && led_expected.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
`default_nettype wire

@@ filelist.f @@
src/dlps_pkg.sv
src/dlps_lane.sv
src/dlps_sequencer.sv
src/debounced_led_pattern_sequencer.sv
tb/sv/debounced_led_pattern_sequencer_tb.sv
